// ===== sv/csv_field_splitter_unit_assert.svh =====
// Assertion macros for the CSV field splitter.
// Included by the top level; each macro checks on the rising edge of aclk, off during reset.
`ifndef CSV_FIELD_SPLITTER_UNIT_ASSERT_SVH
`define CSV_FIELD_SPLITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property that must hold in the same cycle.
`define CSVFS_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("csv field splitter check failed");
// Antecedent in one cycle implies consequent in the next.
`define CSVFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csv field splitter check failed");
`else
`define CSVFS_ASSERT(label, prop)
`define CSVFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/csvfs_pkg.sv =====
// Shared types and constants of the CSV field splitter.
// No dependencies; imported by every module of the block except the RAM.
package csvfs_pkg;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [1:0] MODE_TAB = 2'd2;

    // Width of the held-run length in a command; covers store depths up to 64.
    localparam int CNT_W = 6;

    // Bit positions inside the result tuser.
    localparam int TU_KIND = 0;
    localparam int TU_ENDL = 1;
    localparam int TU_OVF  = 2;
    localparam int TU_W    = 3;

    // One classified item, handed from the front end to the emitter.
    typedef struct packed {
        logic [CNT_W-1:0] flush_cnt;  // held whitespace bytes to replay first
        logic             ovf;        // replay and byte come from a store overflow
        logic             byte_vld;   // one content byte follows the replay
        logic [7:0]       data;
        logic             mark0;      // end of field, line continues
        logic             mark1;      // end of field and end of line
    } cmd_t;

    // Status from the emitter back to the front end.
    typedef struct packed {
        logic flush_done;             // last replayed store byte has left
    } back_sts_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== sv/csvfs_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module csvfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/csvfs_cmd_fifo.sv =====
// Two-entry command queue between the front end and the emitter.
// Depends on csvfs_pkg for the command type.
module csvfs_cmd_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  csvfs_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output csvfs_pkg::cmd_t pop_cmd,
    output logic            not_empty
);
    import csvfs_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== sv/csvfs_front.sv =====
// Front end: accepts input bytes, tracks quoting and field state, holds whitespace
// in the store RAM and issues a command for each item with results. Depends on csvfs_pkg.
module csvfs_front #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_data,
    input  csvfs_pkg::back_sts_t           back_sts,
    input  logic                           fifo_full,
    output logic                           cmd_push,
    output csvfs_pkg::cmd_t                cmd_out,
    output logic                           ram_we,
    output logic [$clog2(SPACE_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                     ram_wdata
);
    import csvfs_pkg::*;

    localparam int CW = $clog2(SPACE_DEPTH);
    localparam logic [CW-1:0] COUNT_FULL = CW'(SPACE_DEPTH - 1);

    logic [1:0]    mode_reg;
    logic          in_quotes_reg, in_quotes_next;
    logic          quote_wait_reg, quote_wait_next;
    logic          field_start_reg, field_start_next;
    logic [CW-1:0] count_reg, count_next;
    logic          lock_reg, lock_next;

    logic   accept;
    logic   zero_byte;
    logic   store_ws;
    cmd_t   cmd;
    logic   has_results;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_full && !lock_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        in_quotes_next   = in_quotes_reg;
        quote_wait_next  = quote_wait_reg;
        field_start_next = field_start_reg;
        count_next       = count_reg;
        store_ws         = 1'b0;
        cmd              = '0;
        zero_byte        = s_tuser && (s_tdata == 8'h00);

        if (s_tuser && !zero_byte) begin
            if (mode_reg == MODE_TAB) begin
                if (s_tdata == CH_TAB) begin
                    cmd.mark0       = 1'b1;
                    count_next      = '0;
                    quote_wait_next = 1'b0;
                    in_quotes_next  = 1'b0;
                end else begin
                    cmd.byte_vld = 1'b1;
                    cmd.data     = s_tdata;
                end
                field_start_next = (s_tdata == CH_TAB);
            end else if (s_tdata == CH_QUOTE) begin
                cmd.flush_cnt    = CNT_W'(count_reg);
                count_next       = '0;
                in_quotes_next   = !in_quotes_reg;
                field_start_next = 1'b0;
                if (quote_wait_reg) begin
                    cmd.byte_vld    = 1'b1;
                    cmd.data        = CH_QUOTE;
                    quote_wait_next = 1'b0;
                end else begin
                    quote_wait_next = 1'b1;
                end
            end else if ((s_tdata == CH_COMMA) && !in_quotes_reg) begin
                cmd.mark0        = 1'b1;
                count_next       = '0;
                quote_wait_next  = 1'b0;
                in_quotes_next   = 1'b0;
                field_start_next = 1'b1;
            end else if (is_ws(s_tdata)) begin
                if (!field_start_reg) begin
                    quote_wait_next = 1'b0;
                    if (count_reg == COUNT_FULL) begin
                        // Run too long to hold: replay it and this byte as content.
                        cmd.flush_cnt = CNT_W'(count_reg);
                        cmd.ovf       = 1'b1;
                        cmd.byte_vld  = 1'b1;
                        cmd.data      = s_tdata;
                        count_next    = '0;
                    end else begin
                        store_ws   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
            end else begin
                cmd.flush_cnt    = CNT_W'(count_reg);
                count_next       = '0;
                quote_wait_next  = 1'b0;
                cmd.byte_vld     = 1'b1;
                cmd.data         = s_tdata;
                field_start_next = 1'b0;
            end
        end

        if (s_tlast || zero_byte) begin
            cmd.mark1        = 1'b1;
            count_next       = '0;
            quote_wait_next  = 1'b0;
            in_quotes_next   = 1'b0;
            field_start_next = 1'b1;
        end

        has_results = (cmd.flush_cnt != '0) || cmd.byte_vld || cmd.mark0 || cmd.mark1;

        // While replayed bytes are still being read out, the store must not change.
        lock_next = lock_reg;
        if (back_sts.flush_done) begin
            lock_next = 1'b0;
        end
        if (accept && (cmd.flush_cnt != '0)) begin
            lock_next = 1'b1;
        end
    end

    assign cmd_push  = accept && has_results;
    assign cmd_out   = cmd;
    assign ram_we    = accept && store_ws;
    assign ram_waddr = count_reg;
    assign ram_wdata = s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= '0;
            in_quotes_reg   <= 1'b0;
            quote_wait_reg  <= 1'b0;
            field_start_reg <= 1'b1;
            count_reg       <= '0;
            lock_reg        <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg        <= cfg_data;
            in_quotes_reg   <= 1'b0;
            quote_wait_reg  <= 1'b0;
            field_start_reg <= 1'b1;
            count_reg       <= '0;
            lock_reg        <= lock_next;
        end else begin
            lock_reg <= lock_next;
            if (accept) begin
                in_quotes_reg   <= in_quotes_next;
                quote_wait_reg  <= quote_wait_next;
                field_start_reg <= field_start_next;
                count_reg       <= count_next;
            end
        end
    end

endmodule

// ===== sv/csvfs_back.sv =====
// Emitter: takes commands from the queue and produces result transactions,
// replaying held whitespace from the store RAM. Depends on csvfs_pkg.
module csvfs_back #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           fifo_not_empty,
    input  csvfs_pkg::cmd_t                fifo_cmd,
    output logic                           fifo_pop,
    output logic                           ram_re,
    output logic [$clog2(SPACE_DEPTH)-1:0] ram_raddr,
    input  logic [7:0]                     ram_rdata,
    output csvfs_pkg::back_sts_t           back_sts,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,
    output logic [csvfs_pkg::TU_W-1:0]     m_tuser,
    output logic                           m_tlast
);
    import csvfs_pkg::*;

    localparam int CW = $clog2(SPACE_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_FLUSH, ST_TAIL} state_t;

    state_t          state_reg, state_next;
    cmd_t            cmd_reg, cmd_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic [CW-1:0]   em_reg, em_next;
    logic            dv_reg, dv_next;
    logic            tvalid_reg, tvalid_next;
    logic [7:0]      tdata_reg, tdata_next;
    logic [TU_W-1:0] tuser_reg, tuser_next;
    logic            tlast_reg, tlast_next;

    logic          out_free;
    logic          emit;
    logic          consume;
    logic          issue;
    logic          tail_left;
    logic [CW-1:0] cnt;

    assign out_free  = !tvalid_reg || m_tready;
    assign cnt       = cmd_reg.flush_cnt[CW-1:0];
    assign tail_left = cmd_reg.byte_vld || cmd_reg.mark0 || cmd_reg.mark1;

    always_comb begin
        state_next         = state_reg;
        cmd_next           = cmd_reg;
        rd_idx_next        = rd_idx_reg;
        em_next            = em_reg;
        dv_next            = dv_reg;
        tdata_next         = tdata_reg;
        tuser_next         = tuser_reg;
        tlast_next         = tlast_reg;
        emit               = 1'b0;
        consume            = 1'b0;
        issue              = 1'b0;
        fifo_pop           = 1'b0;
        back_sts.flush_done = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (fifo_not_empty) begin
                    fifo_pop    = 1'b1;
                    cmd_next    = fifo_cmd;
                    rd_idx_next = '0;
                    em_next     = '0;
                    dv_next     = 1'b0;
                    state_next  = (fifo_cmd.flush_cnt != '0) ? ST_FLUSH : ST_TAIL;
                end
            end
            ST_FLUSH: begin
                consume = dv_reg && out_free;
                issue   = (rd_idx_reg != cnt) && (!dv_reg || consume);
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    dv_next     = 1'b1;
                end else if (consume) begin
                    dv_next = 1'b0;
                end
                if (consume) begin
                    emit                 = 1'b1;
                    tdata_next           = ram_rdata;
                    tuser_next           = '0;
                    tuser_next[TU_OVF]   = cmd_reg.ovf;
                    tlast_next           = (em_reg == cnt - 1'b1) && !tail_left;
                    em_next              = em_reg + 1'b1;
                    if (em_reg == cnt - 1'b1) begin
                        back_sts.flush_done = 1'b1;
                        state_next          = tail_left ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    tuser_next = '0;
                    if (cmd_reg.byte_vld) begin
                        tdata_next         = cmd_reg.data;
                        tuser_next[TU_OVF] = cmd_reg.ovf;
                        tlast_next         = !cmd_reg.mark0 && !cmd_reg.mark1;
                        cmd_next.byte_vld  = 1'b0;
                    end else if (cmd_reg.mark0) begin
                        tdata_next          = 8'h00;
                        tuser_next[TU_KIND] = 1'b1;
                        tlast_next          = !cmd_reg.mark1;
                        cmd_next.mark0      = 1'b0;
                    end else begin
                        tdata_next          = 8'h00;
                        tuser_next[TU_KIND] = 1'b1;
                        tuser_next[TU_ENDL] = 1'b1;
                        tlast_next          = 1'b1;
                        cmd_next.mark1      = 1'b0;
                    end
                    if (tlast_next) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        tvalid_next = emit ? 1'b1 : (m_tready ? 1'b0 : tvalid_reg);
    end

    assign ram_re    = issue;
    assign ram_raddr = rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dv_reg     <= 1'b0;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dv_reg     <= dv_next;
            tvalid_reg <= tvalid_next;
        end
        cmd_reg    <= cmd_next;
        rd_idx_reg <= rd_idx_next;
        em_reg     <= em_next;
        tdata_reg  <= tdata_next;
        tuser_reg  <= tuser_next;
        tlast_reg  <= tlast_next;
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

// ===== sv/csv_field_splitter_unit.sv =====
// Top level of the CSV field splitter: front end, command queue, emitter, whitespace store.
// Depends on csvfs_pkg, csvfs_front, csvfs_cmd_fifo, csvfs_back, csvfs_ram and the assert header.
//
// This block splits a line of text, presented one byte per input transaction, into fields.
// In comma modes (delimiter_mode 0, 1 or 3) a comma outside double quotes ends a field,
// leading and trailing whitespace of a field is dropped, a doubled quote yields one quote
// and a lone quote is removed. In tab mode (delimiter_mode 2) a tab ends a field and all
// other bytes, quotes and whitespace included, are content. A line ends after an input
// transaction with s_tlast set or on a present zero byte; that closes the current field.
// Each input transaction yields zero or more result transactions: content bytes and
// end-of-field markers, the final one of each input flagged by m_tlast. Whitespace inside
// a field is held in a store of SPACE_DEPTH-1 bytes until a later content byte shows it is
// not trailing; a longer run is released as content with the overflow flag set. Timing:
// the front end takes one input transaction per cycle while the two-entry command queue
// has room and no replay holds the input off. The emitter loads a command in its idle
// state and then sends one result per cycle while the output is not stalled; it takes the
// next command only after the last result of the current one, and a replay of held
// whitespace starts with a registered store read. Items that only store whitespace cost
// the emitter nothing. When held whitespace is replayed, input is held off until the
// emitter has moved the last replayed byte into its output register. A replay carries at
// most SPACE_DEPTH-1 bytes.
// Writing delimiter_mode restarts the line state; write it only while the block is idle.
module csv_field_splitter_unit #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input stream.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] byte_present
    input  logic       s_tlast,   // line_end
    // Result stream.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [0] kind, [1] ends_line, [2] space_overflow
    output logic       m_tlast,   // last_of_run
    // Configuration: delimiter_mode.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data
);
    import csvfs_pkg::*;

    localparam int AW = $clog2(SPACE_DEPTH);

    back_sts_t back_sts;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;
    logic      cmd_push;
    logic      cmd_pop;
    logic      fifo_full;
    logic      fifo_not_empty;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // Classifies each input byte and keeps the quoting and field state.
    csvfs_front #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .back_sts  (back_sts),
        .fifo_full (fifo_full),
        .cmd_push  (cmd_push),
        .cmd_out   (push_cmd),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

    // Decouples the front end from the emitter so each side can stall independently.
    csvfs_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (cmd_push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (cmd_pop),
        .pop_cmd   (pop_cmd),
        .not_empty (fifo_not_empty)
    );

    // Holds the pending whitespace run of the current field.
    csvfs_ram #(
        .WIDTH(8),
        .DEPTH(SPACE_DEPTH)
    ) u_space_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Turns each command into result transactions behind a registered output.
    csvfs_back #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fifo_not_empty (fifo_not_empty),
        .fifo_cmd       (pop_cmd),
        .fifo_pop       (cmd_pop),
        .ram_re         (ram_re),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .back_sts       (back_sts),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

`include "csv_field_splitter_unit_assert.svh"

    // The front end never pushes a command into a full queue.
    `CSVFS_ASSERT(a_no_push_when_full, !(cmd_push && fifo_full))
    // The store is never written while the emitter is replaying it.
    `CSVFS_ASSERT(a_no_store_write_during_replay, !(ram_we && ram_re))
    // An end-of-field marker carries a zero data byte and no overflow flag.
    `CSVFS_ASSERT(a_marker_clean,
        !(m_tvalid && m_tuser[TU_KIND]) || ((m_tdata == 8'h00) && !m_tuser[TU_OVF]))
    // A finished replay releases the input side in the next cycle unless the queue is full.
    `CSVFS_ASSERT_NEXT(a_replay_release, back_sts.flush_done && !fifo_full && !cfg_valid,
        s_tready || fifo_full)

endmodule

// ===== tb/csv_field_splitter_unit_checker.sv =====
// Result checker for the CSV field splitter: watches the input, result and mode-write channels.
// Predicts every result from the accepted input transactions and compares it field by field.
// Depends on csvfs_pkg for the character codes, the tab mode code and the tuser bit positions.
module csv_field_splitter_unit_checker #(
    parameter int SPACE_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [2:0] m_tuser,
    input  logic       m_tlast,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_data,
    output int         fail_count,
    output int         pending_count
);
    import csvfs_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       ends_line;
        logic       ovf;
        logic       last;
    } field_result_t;

    field_result_t expected_q[$];
    int            mismatches = 0;

    // Line state of the splitter as this checker sees it.
    logic [1:0] delim_mode = 2'd0;
    bit         in_quotes;
    bit         quote_open;
    bit         at_start = 1'b1;
    logic [7:0] blank_hold[SPACE_DEPTH];
    int         blank_count;

    function automatic bit is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    task automatic expect_result(input logic [7:0] b, input logic k, input logic endl,
                                 input logic ovf);
        field_result_t r;
        r = '{out_byte: b, kind: k, ends_line: endl, ovf: ovf, last: 1'b0};
        expected_q.push_back(r);
    endtask

    task automatic restart_line();
        in_quotes   = 1'b0;
        quote_open  = 1'b0;
        at_start    = 1'b1;
        blank_count = 0;
    endtask

    // Held whitespace turned out to be inside the field, so it becomes content.
    task automatic release_blanks(input logic ovf);
        for (int i = 0; i < blank_count; i++)
            expect_result(blank_hold[i], 1'b0, 1'b0, ovf);
        blank_count = 0;
    endtask

    task automatic close_field(input logic endl);
        restart_line();
        expect_result(8'h00, 1'b1, endl, 1'b0);
    endtask

    task automatic split_item(input logic [7:0] b, input logic present, input logic eol);
        int            first_new;
        logic          line_done;
        field_result_t tail;
        first_new = expected_q.size();
        line_done = eol;
        if (present) begin
            if (b == 8'h00) begin
                line_done = 1'b1;
            end else if (delim_mode == MODE_TAB) begin
                if (b == CH_TAB)
                    close_field(1'b0);
                else
                    expect_result(b, 1'b0, 1'b0, 1'b0);
                at_start = (b == CH_TAB);
            end else if (b == CH_QUOTE) begin
                release_blanks(1'b0);
                in_quotes = !in_quotes;
                if (quote_open) begin
                    expect_result(CH_QUOTE, 1'b0, 1'b0, 1'b0);
                    quote_open = 1'b0;
                end else begin
                    quote_open = 1'b1;
                end
                at_start = 1'b0;
            end else if (b == CH_COMMA && !in_quotes) begin
                close_field(1'b0);
            end else if (is_blank(b)) begin
                if (!at_start) begin
                    quote_open = 1'b0;
                    if (blank_count >= SPACE_DEPTH - 1) begin
                        release_blanks(1'b1);
                        expect_result(b, 1'b0, 1'b0, 1'b1);
                    end else begin
                        blank_hold[blank_count] = b;
                        blank_count++;
                    end
                end
            end else begin
                release_blanks(1'b0);
                quote_open = 1'b0;
                expect_result(b, 1'b0, 1'b0, 1'b0);
                at_start = 1'b0;
            end
        end
        if (line_done)
            close_field(1'b1);
        if (expected_q.size() > first_new) begin
            tail = expected_q.pop_back();
            tail.last = 1'b1;
            expected_q.push_back(tail);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
        end
    endtask

    task automatic check_result();
        field_result_t want;
        if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected nothing, %s %02h %s %03b %s %b",
                     $time, "actual byte", m_tdata, "user", m_tuser, "last", m_tlast);
        end else begin
            want = expected_q.pop_front();
            check_field("out_byte", want.out_byte, m_tdata);
            check_field("kind", {7'd0, want.kind}, {7'd0, m_tuser[TU_KIND]});
            check_field("ends_line", {7'd0, want.ends_line}, {7'd0, m_tuser[TU_ENDL]});
            check_field("space_overflow", {7'd0, want.ovf}, {7'd0, m_tuser[TU_OVF]});
            check_field("last_of_run", {7'd0, want.last}, {7'd0, m_tlast});
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            delim_mode = 2'd0;
            restart_line();
        end else begin
            if (cfg_valid && cfg_ready) begin
                delim_mode = cfg_data;
                restart_line();
            end
            if (s_tvalid && s_tready)
                split_item(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
        end
        fail_count    <= mismatches;
        pending_count <= expected_q.size();
    end

endmodule

// ===== tb/csv_field_splitter_unit_test.sv =====
// Top of the CSV field splitter testbench: clock, reset, stimulus, stall patterns and verdict.
// Depends on csvfs_pkg, the block csv_field_splitter_unit and csv_field_splitter_unit_checker.
module csv_field_splitter_unit_test;
    import csvfs_pkg::*;

    // Mode values written to delimiter_mode; the tab mode code comes from the package.
    // The spare value 3 is read by the block as plain comma mode.
    localparam logic [1:0] MODE_COMMA  = 2'd0;
    localparam logic [1:0] MODE_QUOTED = 2'd1;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam int SPACE_DEPTH    = 32;
    // Quiet cycles granted after the last expected result before the next phase; items which
    // cause no result (stored whitespace, bare items) never enter the command queue.
    localparam int DRAIN_CYCLES   = 64;
    // Long receiver hold-off that fills the block and backs up the input.
    localparam int STALL_CYCLES   = 400;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 4000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tuser   = 1'b0;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_data  = 2'd0;

    int fail_count;
    int pending_results;

    // Idle rates in percent for each side, changed between phases.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // Count of input transactions that carry a byte or a line end.
    int items_sent    = 0;
    // Set by the stimulus, cleared by the receiver once its hold-off is over.
    bit stall_now     = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    csv_field_splitter_unit #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    csv_field_splitter_unit_checker #(
        .SPACE_DEPTH(SPACE_DEPTH)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending_count(pending_results)
    );

    // Offers one input transaction and returns at the edge where it is accepted. The valid
    // stays high on return, so a following call may keep it high with a single assignment.
    task automatic drive_item(input logic [7:0] b, input logic present, input logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (present || eol)
            items_sent++;
    endtask

    // The mode register is written only when no transaction is in flight.
    task automatic write_mode(input logic [1:0] mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering input, waits for every expected result and then lets the block drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Field text that never splits a field: commas and quotes are swapped for a letter.
    function automatic logic [7:0] pick_text();
        logic [7:0] b;
        b = 8'($urandom_range(8'h21, 8'hFF));
        if (b == CH_COMMA || b == CH_QUOTE)
            b = 8'h41;
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        int k;
        k = $urandom_range(5);
        return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
    endfunction

    // Four ways a line can end: zero byte, bare line end, a byte or a separator with tlast.
    task automatic end_line(input bit tab_mode);
        case ($urandom_range(3))
            0: drive_item(8'h00, 1'b1, 1'b0);
            1: drive_item(8'h00, 1'b0, 1'b1);
            2: drive_item(pick_text(), 1'b1, 1'b1);
            default: drive_item(tab_mode ? CH_TAB : CH_COMMA, 1'b1, 1'b1);
        endcase
    endtask

    // One comma-mode field with padding: plain text, quoted text with embedded commas and
    // doubled quotes, or text around a long whitespace run that may overflow the store.
    task automatic send_comma_field();
        int shape;
        shape = $urandom_range(9);
        repeat ($urandom_range(2)) drive_item(pick_blank(), 1'b1, 1'b0);
        if (shape < 3) begin
            drive_item(CH_QUOTE, 1'b1, 1'b0);
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(5))
                    0: drive_item(CH_COMMA, 1'b1, 1'b0);
                    1: begin
                        drive_item(CH_QUOTE, 1'b1, 1'b0);
                        drive_item(CH_QUOTE, 1'b1, 1'b0);
                    end
                    2: drive_item(pick_blank(), 1'b1, 1'b0);
                    default: drive_item(pick_text(), 1'b1, 1'b0);
                endcase
            end
            // Now and then the closing quote is left out.
            if ($urandom_range(5) != 0)
                drive_item(CH_QUOTE, 1'b1, 1'b0);
        end else if (shape == 9) begin
            drive_item(pick_text(), 1'b1, 1'b0);
            repeat ($urandom_range(20, 70)) drive_item(pick_blank(), 1'b1, 1'b0);
            drive_item(pick_text(), 1'b1, 1'b0);
        end else begin
            repeat ($urandom_range(6)) begin
                if ($urandom_range(3) == 0)
                    drive_item(pick_blank(), 1'b1, 1'b0);
                else
                    drive_item(pick_text(), 1'b1, 1'b0);
            end
        end
        repeat ($urandom_range(2)) drive_item(pick_blank(), 1'b1, 1'b0);
    endtask

    task automatic send_line(input bit tab_mode);
        int   fields;
        logic [7:0] b;
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            if (tab_mode) begin
                repeat ($urandom_range(6)) begin
                    b = 8'($urandom_range(1, 255));
                    drive_item((b == CH_TAB) ? CH_QUOTE : b, 1'b1, 1'b0);
                end
            end else begin
                send_comma_field();
            end
            if (f < fields - 1)
                drive_item(tab_mode ? CH_TAB : CH_COMMA, 1'b1, 1'b0);
        end
        end_line(tab_mode);
    endtask

    // Mostly well-formed lines, with short bursts of arbitrary transactions in between.
    task automatic run_random(input int target, input bit tab_mode);
        while (items_sent < target) begin
            if ($urandom_range(4) == 0) begin
                repeat ($urandom_range(1, 4))
                    drive_item(8'($urandom), $urandom_range(3) != 0, $urandom_range(7) == 0);
            end else begin
                send_line(tab_mode);
            end
        end
    endtask

    // Receiver: random ready, or one long hold-off on request.
    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (stall_now) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(posedge aclk);
                stall_now = 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Any accepted transaction on any channel counts as progress.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Comma mode with a slow receiver: directed cases first.
        send_idle_pct = 27;
        recv_idle_pct = 82;
        write_mode(MODE_COMMA);
        drive_item(CH_SPACE, 1'b1, 1'b0);   // leading whitespace is dropped
        drive_item(8'h41, 1'b1, 1'b0);
        drive_item(CH_SPACE, 1'b1, 1'b0);   // held until the next content byte
        drive_item(CH_TAB, 1'b1, 1'b0);
        drive_item(8'h42, 1'b1, 1'b0);      // releases the held run as content
        drive_item(CH_CR, 1'b1, 1'b0);
        drive_item(CH_COMMA, 1'b1, 1'b0);   // trailing whitespace is dropped
        drive_item(CH_QUOTE, 1'b1, 1'b0);
        drive_item(CH_COMMA, 1'b1, 1'b0);   // comma inside quotes is content
        drive_item(CH_QUOTE, 1'b1, 1'b0);
        drive_item(CH_QUOTE, 1'b1, 1'b0);   // doubled quote yields one quote
        drive_item(CH_QUOTE, 1'b1, 1'b0);   // lone quote is removed
        drive_item(8'hFF, 1'b1, 1'b0);
        drive_item(CH_COMMA, 1'b1, 1'b1);   // separator and line end: two markers
        drive_item(8'h00, 1'b1, 1'b0);      // present zero byte ends the line
        drive_item(8'h00, 1'b0, 1'b0);      // bare item: nothing at all
        drive_item(8'h00, 1'b0, 1'b1);      // bare line end closes an empty field
        drive_item(8'h01, 1'b1, 1'b0);
        drive_item(CH_QUOTE, 1'b1, 1'b1);   // unterminated quote closed by the line end
        drive_item(8'h00, 1'b1, 1'b1);      // zero byte together with the line end
        drive_item(CH_SPACE, 1'b1, 1'b1);
        run_random(75, 1'b0);
        settle();

        // Tab mode with a slow sender.
        send_idle_pct = 82;
        recv_idle_pct = 27;
        write_mode(MODE_TAB);
        drive_item(CH_SPACE, 1'b1, 1'b0);   // whitespace and quotes are content here
        drive_item(CH_QUOTE, 1'b1, 1'b0);
        drive_item(CH_COMMA, 1'b1, 1'b0);
        drive_item(CH_TAB, 1'b1, 1'b0);
        drive_item(CH_CR, 1'b1, 1'b0);
        drive_item(CH_TAB, 1'b1, 1'b1);
        drive_item(8'hFF, 1'b1, 1'b0);
        drive_item(8'h00, 1'b1, 1'b0);
        drive_item(8'h80, 1'b1, 1'b1);
        run_random(120, 1'b1);
        settle();

        // Spare mode value, no idling, and one long receiver hold-off while input keeps coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_mode(MODE_SPARE);
        stall_now = 1'b1;
        run_random(165, 1'b0);
        settle();

        write_mode(MODE_QUOTED);
        run_random(200, 1'b0);
        settle();

        if (fail_count == 0 && pending_results == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
